// ----- src/kcu_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the centroid update block.
package kcu_pkg;

  // Sizing
  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_DIM      = 64;
  localparam int COUNT_BITS   = 16;
  localparam int CL_W         = $clog2(MAX_CLUSTERS);
  localparam int DIM_W        = $clog2(MAX_DIM);
  localparam int ADDR_W       = CL_W + DIM_W;
  localparam int SUM_DEPTH    = MAX_CLUSTERS * MAX_DIM;
  localparam int SUM_W        = 48;
  localparam int VAL_W        = 32;
  localparam int ND_W         = 7;
  localparam int DIV_STEP_W   = $clog2(SUM_W);

  // Register reset and count ceiling
  localparam logic [ND_W-1:0]       NUM_DIMS_RST = ND_W'(MAX_DIM);
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT  = '1;

  // Request command codes
  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic latch_in;    // capture the accepted request
    logic acc_rd;      // read the sum addressed by the incoming request
    logic acc_wr;      // write back the saturated sum
    logic cnt_inc;     // count the item
    logic ro_rd;       // read the sum of the current readout component
    logic ro_zero_wr;  // clear the sum of the current readout component
    logic div_start;   // launch the divider
    logic out_load;    // load the result register
    logic k_clr;       // restart the component counter
    logic k_inc;       // next component
    logic cnt_clr;     // clear the cluster count
    logic sweep_wr;    // reset clearing pass, one entry
  } kcu_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic sweep_last;
    logic cmd_read;
    logic cnt_full;
    logic comp_ok;
    logic item_end;
    logic cnt_zero;
    logic k_active;
    logic k_last;
    logic div_busy;
    logic out_free;
  } kcu_status_t;

endpackage

// ----- src/kcu_div.sv -----
// Radix-2 restoring divider: 48-bit magnitude by a nonzero count, one quotient bit per cycle.
module kcu_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [kcu_pkg::SUM_W-1:0]      dividend_i,
  input  logic [kcu_pkg::COUNT_BITS-1:0] divisor_i,
  output logic                           busy_o,
  output logic [kcu_pkg::SUM_W-1:0]      quotient_o
);

  logic                           busy_q;
  logic [kcu_pkg::DIV_STEP_W-1:0] step_q;
  logic [kcu_pkg::SUM_W-1:0]      quo_q;
  logic [kcu_pkg::COUNT_BITS-1:0] rem_q;
  logic [kcu_pkg::COUNT_BITS-1:0] den_q;

  logic [kcu_pkg::COUNT_BITS:0]   rem_sh;
  logic                           ge;
  logic [kcu_pkg::COUNT_BITS:0]   rem_sub;

  // One shift-subtract step
  always_comb begin
    rem_sh  = {rem_q, quo_q[kcu_pkg::SUM_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  // Control: busy from start until the last shift-subtract step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + kcu_pkg::DIV_STEP_W'(1);
      if (step_q == kcu_pkg::DIV_STEP_W'(kcu_pkg::SUM_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[kcu_pkg::SUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[kcu_pkg::COUNT_BITS-1:0] : rem_sh[kcu_pkg::COUNT_BITS-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  // A new division never cuts into a running one
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

// ----- src/kcu_datapath.sv -----
// Datapath: sum memory, cluster counts, divider, mean saturation and result register.
module kcu_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kcu_pkg::ND_W-1:0]       cfg_wdata_i,
  input  logic                           cmd_i,
  input  logic [kcu_pkg::CL_W-1:0]       cluster_id_i,
  input  logic [kcu_pkg::DIM_W-1:0]      component_index_i,
  input  logic signed [kcu_pkg::VAL_W-1:0] value_i,
  input  logic                           item_end_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [kcu_pkg::DIM_W-1:0]      out_index_o,
  output logic signed [kcu_pkg::VAL_W-1:0] mean_o,
  output logic                           empty_res_o,
  output logic                           last_o,
  input  kcu_pkg::kcu_cmd_t              ctrl_i,
  output kcu_pkg::kcu_status_t           status_o
);

  localparam int SW = kcu_pkg::SUM_W;
  localparam int VW = kcu_pkg::VAL_W;

  // Saturation limits, sum and mean
  localparam logic [SW-1:0] SUM_POS_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SUM_NEG_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0] MAG_POS_LIM = {{(SW-VW){1'b0}}, 1'b0, {(VW-1){1'b1}}};
  localparam logic [SW-1:0] MAG_NEG_LIM = {{(SW-VW){1'b0}}, 1'b1, {(VW-1){1'b0}}};

  logic [kcu_pkg::ND_W-1:0]       dims_q;
  logic [kcu_pkg::CL_W-1:0]       cl_q;
  logic [kcu_pkg::DIM_W-1:0]      comp_q;
  logic [VW-1:0]                  val_q;
  logic                           iend_q;
  logic [kcu_pkg::DIM_W-1:0]      k_q;
  logic [kcu_pkg::ADDR_W-1:0]     sweep_q;
  logic [kcu_pkg::COUNT_BITS-1:0] count_q [kcu_pkg::MAX_CLUSTERS];
  logic [SW-1:0]                  sum_mem [kcu_pkg::SUM_DEPTH];
  logic [SW-1:0]                  rd_q;
  logic                           neg_q;

  logic                           out_valid_q;
  logic [kcu_pkg::DIM_W-1:0]      out_index_q;
  logic [VW-1:0]                  mean_q;
  logic                           empty_q;
  logic                           last_q;

  logic                           mem_we;
  logic                           mem_re;
  logic [kcu_pkg::ADDR_W-1:0]     waddr;
  logic [kcu_pkg::ADDR_W-1:0]     raddr;
  logic [SW-1:0]                  wdata;
  logic [SW:0]                    sum_ext;
  logic [SW-1:0]                  sum_sat;
  logic [SW-1:0]                  dividend;
  logic [SW-1:0]                  quotient;
  logic                           div_busy;
  logic [VW-1:0]                  mean_d;
  logic                           last_d;
  logic [kcu_pkg::COUNT_BITS-1:0] cnt_cur;
  logic                           out_free;

  // Component count register, clamped on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= kcu_pkg::NUM_DIMS_RST;
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        dims_q <= kcu_pkg::ND_W'(1);
      end else if (cfg_wdata_i > kcu_pkg::ND_W'(kcu_pkg::MAX_DIM)) begin
        dims_q <= kcu_pkg::ND_W'(kcu_pkg::MAX_DIM);
      end else begin
        dims_q <= cfg_wdata_i;
      end
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      cl_q   <= cluster_id_i;
      comp_q <= component_index_i;
      val_q  <= value_i;
      iend_q <= item_end_i;
    end
  end

  // Readout component counter and reset sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      sweep_q <= '0;
    end else begin
      if (ctrl_i.k_clr) begin
        k_q <= '0;
      end else if (ctrl_i.k_inc) begin
        k_q <= k_q + kcu_pkg::DIM_W'(1);
      end
      if (ctrl_i.sweep_wr) begin
        sweep_q <= sweep_q + kcu_pkg::ADDR_W'(1);
      end
    end
  end

  // Cluster item counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kcu_pkg::MAX_CLUSTERS; i++) begin
        count_q[i] <= '0;
      end
    end else if (ctrl_i.cnt_clr) begin
      count_q[cl_q] <= '0;
    end else if (ctrl_i.cnt_inc) begin
      count_q[cl_q] <= count_q[cl_q] + kcu_pkg::COUNT_BITS'(1);
    end
  end

  assign cnt_cur = count_q[cl_q];

  // Saturating 48-bit accumulate
  always_comb begin
    sum_ext = {rd_q[SW-1], rd_q} + {{(SW+1-VW){val_q[VW-1]}}, val_q};
    if (sum_ext[SW] != sum_ext[SW-1]) begin
      sum_sat = sum_ext[SW] ? SUM_NEG_MIN : SUM_POS_MAX;
    end else begin
      sum_sat = sum_ext[SW-1:0];
    end
  end

  // Memory port selection
  always_comb begin
    mem_we = ctrl_i.sweep_wr | ctrl_i.acc_wr | ctrl_i.ro_zero_wr;
    mem_re = ctrl_i.acc_rd | ctrl_i.ro_rd;
    if (ctrl_i.sweep_wr) begin
      waddr = sweep_q;
    end else if (ctrl_i.acc_wr) begin
      waddr = {cl_q, comp_q};
    end else begin
      waddr = {cl_q, k_q};
    end
    wdata = ctrl_i.acc_wr ? sum_sat : '0;
    raddr = ctrl_i.acc_rd ? {cluster_id_i, component_index_i} : {cl_q, k_q};
  end

  // Sum memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sum_mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_q <= sum_mem[raddr];
    end
  end

  // Divide magnitude, keep sign aside
  assign dividend = rd_q[SW-1] ? (~rd_q + SW'(1)) : rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      neg_q <= rd_q[SW-1];
    end
  end

  kcu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (cnt_cur),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Signed mean with 32-bit saturation
  always_comb begin
    if (cnt_cur == '0) begin
      mean_d = '0;
    end else if (!neg_q) begin
      mean_d = (quotient > MAG_POS_LIM) ? MAG_POS_LIM[VW-1:0] : quotient[VW-1:0];
    end else begin
      mean_d = (quotient > MAG_NEG_LIM) ? MAG_NEG_LIM[VW-1:0]
                                        : (~quotient[VW-1:0] + VW'(1));
    end
    last_d = (kcu_pkg::ND_W'(k_q) + kcu_pkg::ND_W'(1)) == dims_q;
  end

  // Result register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_index_q <= k_q;
      mean_q      <= mean_d;
      empty_q     <= (cnt_cur == '0);
      last_q      <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign mean_o      = mean_q;
  assign empty_res_o = empty_q;
  assign last_o      = last_q;

  // Status to controller
  always_comb begin
    status_o.sweep_last = sweep_q == kcu_pkg::ADDR_W'(kcu_pkg::SUM_DEPTH - 1);
    status_o.cmd_read   = cmd_i == kcu_pkg::CMD_READ;
    status_o.cnt_full   = cnt_cur == kcu_pkg::COUNT_LIMIT;
    status_o.comp_ok    = {1'b0, comp_q} < dims_q;
    status_o.item_end   = iend_q;
    status_o.cnt_zero   = cnt_cur == '0;
    status_o.k_active   = {1'b0, k_q} < dims_q;
    status_o.k_last     = k_q == kcu_pkg::DIM_W'(kcu_pkg::MAX_DIM - 1);
    status_o.div_busy   = div_busy;
    status_o.out_free   = out_free;
  end

  // Pending result is never overwritten
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |-> out_free)
    else $error("result register loaded while a result is pending");

  // No division by an empty count
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.div_start |-> (cnt_cur != '0))
    else $error("divider started with zero count");

  // Accumulate write only when the cluster still takes items and the component is in use
  a_acc_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.acc_wr |-> (cnt_cur != kcu_pkg::COUNT_LIMIT) && status_o.comp_ok)
    else $error("sum written for a dropped component");

  // At most one writer on the memory port
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_i.sweep_wr, ctrl_i.acc_wr, ctrl_i.ro_zero_wr}))
    else $error("conflicting sum memory writes");

endmodule

// ----- src/kcu_ctrl.sv -----
// Controller state machine: reset clearing pass, accumulate read-modify-write, readout sequencing.
module kcu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  kcu_pkg::kcu_status_t status_i,
  output kcu_pkg::kcu_cmd_t    ctrl_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      S_CLEAR: begin
        ctrl_o.sweep_wr = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.latch_in = 1'b1;
          if (status_i.cmd_read) begin
            ctrl_o.k_clr = 1'b1;
            state_d      = S_RD;
          end else begin
            ctrl_o.acc_rd = 1'b1;
            state_d       = S_ACC;
          end
        end
      end
      S_ACC: begin
        ctrl_o.acc_wr  = !status_i.cnt_full && status_i.comp_ok;
        ctrl_o.cnt_inc = !status_i.cnt_full && status_i.item_end;
        state_d        = S_IDLE;
      end
      S_RD: begin
        ctrl_o.ro_rd = 1'b1;
        state_d      = S_LOAD;
      end
      S_LOAD: begin
        ctrl_o.ro_zero_wr = 1'b1;
        if (status_i.k_active) begin
          if (status_i.cnt_zero) begin
            state_d = S_OUT;
          end else begin
            ctrl_o.div_start = 1'b1;
            state_d          = S_DIV;
          end
        end else if (status_i.k_last) begin
          state_d = S_FIN;
        end else begin
          ctrl_o.k_inc = 1'b1;
          state_d      = S_RD;
        end
      end
      S_DIV: begin
        if (!status_i.div_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          if (status_i.k_last) begin
            state_d = S_FIN;
          end else begin
            ctrl_o.k_inc = 1'b1;
            state_d      = S_RD;
          end
        end
      end
      S_FIN: begin
        ctrl_o.cnt_clr = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/kcu_centroid_update_top_note_placeholder.sv -----
// Result ordering check: readout results carry ascending component indexes.
module kcu_order_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_stall_i,
  input logic [kcu_pkg::DIM_W-1:0] out_index_i,
  input logic                      last_i
);

  logic                      seen_q;
  logic                      prev_last_q;
  logic [kcu_pkg::DIM_W-1:0] prev_idx_q;
  logic                      take;

  assign take = out_valid_i && !out_stall_i;

  // Track the previous delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      prev_last_q <= 1'b1;
      prev_idx_q  <= '0;
    end else if (take) begin
      seen_q      <= 1'b1;
      prev_last_q <= last_i;
      prev_idx_q  <= out_index_i;
    end
  end

  // A readout starts at component zero
  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && prev_last_q |-> out_index_i == '0)
    else $error("readout does not start at component zero");

  // Within a readout, indexes step by one
  a_step_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && seen_q && !prev_last_q |-> out_index_i == prev_idx_q + kcu_pkg::DIM_W'(1))
    else $error("readout component index skipped");

endmodule

// ----- src/kmeans_centroid_update.sv -----
// Top level of the k-means centroid update block: controller and datapath.
// Accumulate request: memory read, then saturating add and write back.
// Readout: each active component is read and divided (48-step serial divider), except in
//   an empty cluster; unused components just have sums cleared. Accept first, clear last.
// Reset: counts clear at once; a pass over all 1024 entries zeroes the sum memory, input
//   stalled meanwhile, register writes still taken.
module kmeans_centroid_update (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kcu_pkg::ND_W-1:0]         cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             cmd_i,
  input  logic [kcu_pkg::CL_W-1:0]         cluster_id_i,
  input  logic [kcu_pkg::DIM_W-1:0]        component_index_i,
  input  logic signed [kcu_pkg::VAL_W-1:0] value_i,
  input  logic                             item_end_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [kcu_pkg::DIM_W-1:0]        out_index_o,
  output logic signed [kcu_pkg::VAL_W-1:0] mean_o,
  output logic                             empty_res_o,
  output logic                             last_o
);

  kcu_pkg::kcu_cmd_t    ctrl;
  kcu_pkg::kcu_status_t status;

  kcu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  kcu_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd_i),
    .cluster_id_i      (cluster_id_i),
    .component_index_i (component_index_i),
    .value_i           (value_i),
    .item_end_i        (item_end_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .out_index_o       (out_index_o),
    .mean_o            (mean_o),
    .empty_res_o       (empty_res_o),
    .last_o            (last_o),
    .ctrl_i            (ctrl),
    .status_o          (status)
  );

  kcu_order_chk u_order_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_index_i (out_index_o),
    .last_i      (last_o)
  );

endmodule

// ----- verif/kmeans_centroid_update_tb.sv -----
// Self-checking testbench for kmeans_centroid_update: request driver, result monitor, mean predictor.
module kmeans_centroid_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CL_W         = kcu_pkg::CL_W;
  localparam int DIM_W        = kcu_pkg::DIM_W;
  localparam int VAL_W        = kcu_pkg::VAL_W;
  localparam int ND_W         = kcu_pkg::ND_W;
  localparam int MAX_CLUSTERS = kcu_pkg::MAX_CLUSTERS;
  localparam int MAX_DIM      = kcu_pkg::MAX_DIM;
  localparam logic [ND_W-1:0]                NUM_DIMS_RST = kcu_pkg::NUM_DIMS_RST;
  localparam logic [kcu_pkg::COUNT_BITS-1:0] COUNT_LIMIT  = kcu_pkg::COUNT_LIMIT;
  localparam logic CMD_ACC  = kcu_pkg::CMD_ACC;
  localparam logic CMD_READ = kcu_pkg::CMD_READ;

  localparam int     WATCHDOG_LIMIT = 20000;
  localparam int     SETTLE_CYCLES  = 300;    // readout clears unused sums after its last result
  localparam int     IDLE_PCT       = 9;
  localparam int     RX_HOLD_CYCLES = 400;
  localparam int     MAX_REPORTS    = 40;
  localparam longint SUM_HI         = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO         = -SUM_HI - 1;
  localparam longint MEAN_HI        = 64'sh0000_0000_7FFF_FFFF;
  localparam longint MEAN_LO        = -MEAN_HI - 1;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef struct {
    logic                    cmd;
    logic [CL_W-1:0]         cl;
    logic [DIM_W-1:0]        comp;
    logic signed [VAL_W-1:0] val;
    logic                    iend;
  } centroid_req_t;

  typedef struct {
    logic [DIM_W-1:0]        idx;
    logic signed [VAL_W-1:0] mean;
    logic                    is_empty;
    logic                    is_last;
  } centroid_mean_t;

  logic                    clk_i             = 1'b0;
  logic                    rst_ni            = 1'b0;
  logic                    cfg_we_i          = 1'b0;
  logic [ND_W-1:0]         cfg_wdata_i       = '0;
  logic                    in_valid_i        = 1'b0;
  logic                    in_stall_o;
  logic                    cmd_i             = CMD_ACC;
  logic [CL_W-1:0]         cluster_id_i      = '0;
  logic [DIM_W-1:0]        component_index_i = '0;
  logic signed [VAL_W-1:0] value_i           = '0;
  logic                    item_end_i        = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i       = 1'b0;
  logic [DIM_W-1:0]        out_index_o;
  logic signed [VAL_W-1:0] mean_o;
  logic                    empty_res_o;
  logic                    last_o;

  // Predictor state
  longint          sum_model [MAX_CLUSTERS][MAX_DIM];
  int unsigned     count_model [MAX_CLUSTERS];
  logic [ND_W-1:0] dims_model = NUM_DIMS_RST;

  centroid_req_t   pending_q[$];
  centroid_mean_t  mean_q[$];
  centroid_req_t   drv_req;
  centroid_req_t   seen_req;
  int              err_cnt      = 0;
  int              quiet_cycles = 0;
  int              in_idle_pct  = IDLE_PCT;
  int              out_idle_pct = IDLE_PCT;
  int              rx_hold_left = 0;
  bit              rx_hold_req  = 1'b0;
  bit              in_fire      = 1'b0;
  bit              out_fire     = 1'b0;

  kmeans_centroid_update u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .cluster_id_i      (cluster_id_i),
    .component_index_i (component_index_i),
    .value_i           (value_i),
    .item_end_i        (item_end_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_index_o       (out_index_o),
    .mean_o            (mean_o),
    .empty_res_o       (empty_res_o),
    .last_o            (last_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Effective component count: 0 acts as 1, large values clamp to MAX_DIM
  function automatic int dims_in_use();
    if (dims_model == '0) return 1;
    if (int'(dims_model) > MAX_DIM) return MAX_DIM;
    return int'(dims_model);
  endfunction

  // Apply one accepted request to the model, queue the means a readout produces
  task automatic update_centroids(input centroid_req_t req);
    int             dims;
    longint         acc;
    longint         q;
    centroid_mean_t res;
    dims = dims_in_use();
    if (req.cmd == CMD_ACC) begin
      if (count_model[req.cl] >= COUNT_LIMIT) return;  // cluster full: request dropped
      if (int'(req.comp) < dims) begin
        acc = sum_model[req.cl][req.comp] + longint'(req.val);
        if (acc > SUM_HI) acc = SUM_HI;
        else if (acc < SUM_LO) acc = SUM_LO;
        sum_model[req.cl][req.comp] = acc;
      end
      if (req.iend) count_model[req.cl]++;
    end else begin
      for (int k = 0; k < dims; k++) begin
        q = 0;
        if (count_model[req.cl] != 0) begin
          q = sum_model[req.cl][k] / longint'(count_model[req.cl]);
          if (q > MEAN_HI) q = MEAN_HI;
          else if (q < MEAN_LO) q = MEAN_LO;
        end
        res.idx      = DIM_W'(k);
        res.mean     = VAL_W'(q);
        res.is_empty = (count_model[req.cl] == 0);
        res.is_last  = (k == dims - 1);
        mean_q.insert(mean_q.size(), res);
      end
      // readout clears every sum of the cluster, used or not
      for (int k = 0; k < MAX_DIM; k++) sum_model[req.cl][k] = 0;
      count_model[req.cl] = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_mean();
    centroid_mean_t want;
    if (mean_q.size() == 0) begin
      report_mismatch("unexpected result, index", out_index_o, -1);
      return;
    end
    want = mean_q.pop_front();
    if (out_index_o !== want.idx) report_mismatch("out_index", out_index_o, want.idx);
    if (mean_o !== want.mean) report_mismatch("mean", mean_o, want.mean);
    if (empty_res_o !== want.is_empty) report_mismatch("empty_res", empty_res_o, want.is_empty);
    if (last_o !== want.is_last) report_mismatch("last", last_o, want.is_last);
  endtask

  // Monitor: sample both handshakes at the rising edge, plus the watchdog
  always @(posedge clk_i) begin
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (out_fire) check_mean();
    if (in_fire) begin
      seen_req.cmd  = cmd_i;
      seen_req.cl   = cluster_id_i;
      seen_req.comp = component_index_i;
      seen_req.val  = value_i;
      seen_req.iend = item_end_i;
      update_centroids(seen_req);
    end
    quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL kmeans_centroid_update");
      $finish;
    end
  end

  // Request driver: a new request only once the current one was taken
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        drv_req = pending_q.pop_front();
        in_valid_i        <= 1'b1;
        cmd_i             <= drv_req.cmd;
        cluster_id_i      <= drv_req.cl;
        component_index_i <= drv_req.comp;
        value_i           <= drv_req.val;
        item_end_i        <= drv_req.iend;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  task automatic push_acc(input logic [CL_W-1:0] cl, input logic [DIM_W-1:0] comp,
                          input logic signed [VAL_W-1:0] val, input logic iend);
    centroid_req_t req;
    req.cmd  = CMD_ACC;
    req.cl   = cl;
    req.comp = comp;
    req.val  = val;
    req.iend = iend;
    pending_q.insert(pending_q.size(), req);
  endtask

  // Readout; the other fields carry junk that must be ignored
  task automatic push_read(input logic [CL_W-1:0] cl);
    centroid_req_t req;
    req.cmd  = CMD_READ;
    req.cl   = cl;
    req.comp = DIM_W'($urandom);
    req.val  = $urandom;
    req.iend = 1'($urandom);
    pending_q.insert(pending_q.size(), req);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return VAL_W'($urandom_range(262143)) - 32'd131072;
      1: return VAL_MAX;
      2: return VAL_MIN;
      3: return (VAL_W'($urandom_range(400)) - 32'd200) << 16;
      default: return $urandom;
    endcase
  endfunction

  // Mostly whole items in component order, some broken items, readouts and noise
  task automatic run_random(input int budget);
    int              sent;
    int              pick;
    int              dims;
    int              len;
    logic [CL_W-1:0] cl;
    sent = 0;
    dims = dims_in_use();
    while (sent < budget) begin
      pick = $urandom_range(99);
      cl   = ($urandom_range(3) == 0) ? CL_W'($urandom) : CL_W'($urandom_range(3));
      if (pick < 12) begin
        push_read(cl);
        sent++;
      end else if (pick < 22) begin
        push_acc(cl, DIM_W'($urandom), $urandom, 1'($urandom));
        sent++;
      end else begin
        len = (pick < 30) ? $urandom_range(dims) : dims;
        for (int k = 0; k < len; k++)
          push_acc(cl, DIM_W'(k), rand_value(),
                   (k == len - 1) ? ((pick < 30) ? 1'($urandom) : 1'b1) : 1'b0);
        sent += len;
      end
    end
  endtask

  task automatic write_dims(input logic [ND_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    dims_model = v;
  endtask

  // Wait until all requests are taken and all means are back, then let the block settle
  task automatic drain_results();
    while (pending_q.size() != 0 || in_valid_i || mean_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty cluster, saturated means, ignored components, truncation
    write_dims(7'd4);
    push_read(4'd3);
    push_acc(4'd0, 6'd0, VAL_MAX, 1'b0);
    push_acc(4'd0, 6'd0, VAL_MAX, 1'b0);
    push_acc(4'd0, 6'd1, VAL_MIN, 1'b0);
    push_acc(4'd0, 6'd1, VAL_MIN, 1'b0);
    push_acc(4'd0, 6'd2, -32'sd3, 1'b0);
    push_acc(4'd0, 6'd3, 32'sd7, 1'b0);
    push_acc(4'd0, 6'd63, $urandom, 1'b0);
    push_acc(4'd0, 6'd4, $urandom, 1'b1);
    push_read(4'd0);
    push_read(4'd0);
    push_acc(4'd15, 6'd0, -32'sd7, 1'b0);
    push_acc(4'd15, 6'd1, 32'sd7, 1'b1);
    push_acc(4'd15, 6'd0, 32'sd0, 1'b0);
    push_acc(4'd15, 6'd2, 32'h0001_0000, 1'b1);
    push_read(4'd15);
    push_acc(4'd10, 6'd3, -32'sd1, 1'b1);
    push_acc(4'd10, 6'd0, 32'h0000_8000, 1'b1);
    push_read(4'd10);
    drain_results();

    // Zero acts as one component
    write_dims(7'd0);
    run_random(30);
    drain_results();

    // Stretch without any idling on either side
    write_dims(7'd5);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(50);
    drain_results();
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;

    write_dims(7'd64);
    run_random(20);
    drain_results();

    // Above MAX_DIM clamps
    write_dims(7'd127);
    run_random(10);
    drain_results();

    // Receiver holds off while requests keep coming, so the input backs up
    write_dims(7'd13);
    run_random(15);
    @(posedge clk_i);
    rx_hold_req = 1'b1;
    for (int k = 0; k < 13; k++) push_acc(4'd2, DIM_W'(k), rand_value(), k == 12);
    push_read(4'd2);
    for (int k = 0; k < 13; k++) push_acc(4'd2, DIM_W'(k), rand_value(), k == 12);
    push_read(4'd2);
    run_random(25);
    drain_results();

    write_dims(7'd1);
    run_random(30);
    drain_results();

    write_dims(7'd37);
    run_random(30);
    drain_results();

    // Cluster 9: empty readout, then both means saturate, then empty again
    write_dims(7'd2);
    push_read(4'd9);
    repeat (3) begin
      push_acc(4'd9, 6'd0, VAL_MIN, 1'b0);
      push_acc(4'd9, 6'd1, VAL_MAX, 1'b0);
    end
    push_acc(4'd9, 6'd0, VAL_MIN, 1'b0);
    push_acc(4'd9, 6'd1, VAL_MAX, 1'b1);
    push_read(4'd9);
    push_read(4'd9);
    drain_results();

    if (err_cnt == 0) begin
      $display("PASS kmeans_centroid_update");
    end else begin
      $display("FAIL kmeans_centroid_update");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/kcu_pkg.sv
src/kcu_div.sv
src/kcu_datapath.sv
src/kcu_ctrl.sv
src/kcu_centroid_update_top_note_placeholder.sv
src/kmeans_centroid_update.sv
verif/kmeans_centroid_update_tb.sv
